/* src/u16u8_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int UnitW = 16;
    localparam int ByteW = 8;
    localparam int MaxBytes = 4;
    localparam int CntW = 2;
    localparam int HeldW = 10;
    localparam int CpW = 21;

    localparam logic [5:0] HighTag = 6'b110110;
    localparam logic [5:0] LowTag = 6'b110111;
    localparam logic [CpW-1:0] SuppBase = 21'h010000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NUL      = 2'd1,
        ST_UNPAIRED = 2'd2
    } status_t;

    typedef struct packed {
        logic [MaxBytes-1:0][ByteW-1:0] bytes;
        logic [CntW-1:0]                cnt;
        logic                           str_end;
        status_t                        status;
    } group_t;

endpackage

/* src/utf16_to_utf8_transcoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// UTF-16 code units in, strict UTF-8 bytes out, with error beats.
// ----------------------------------------------------------------------------
// one UTF-16 unit is taken per beat; it yields 0 to 4 output beats (1 to 3 for
// a BMP unit, 4 for a surrogate pair on the low half, none for a held high half
// or a dropped unit), and the output sends one byte per cycle unless m_tready
// holds it back. the next unit is taken in the same cycle as the last byte of
// the previous group moves to the output register. an error (NUL, unpaired
// surrogate) is one beat with byte zero, tlast set and string end set; the
// rest of that string is then dropped
module utf16_to_utf8_transcoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // code_unit
    input  logic        s_tlast,   // last_unit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,   // last_of_run
    output logic [2:0]  m_tuser    // status[1:0], string_end
);
    import u16u8_pkg::*;

    logic     unit_accept;
    logic     has_result;
    group_t   dec_grp;
    logic     grp_ready;
    logic     out_end;
    status_t  out_status;

    assign s_tready    = grp_ready;
    assign unit_accept = s_tvalid && grp_ready;

    u16u8_decoder u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .unit_accept (unit_accept),
        .code_unit   (s_tdata),
        .last_unit   (s_tlast),
        .has_result  (has_result),
        .grp         (dec_grp)
    );

    u16u8_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (unit_accept && has_result),
        .in_grp     (dec_grp),
        .grp_ready  (grp_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_run    (m_tlast),
        .out_end    (out_end),
        .out_status (out_status)
    );

    assign m_tuser = {out_status, out_end};

endmodule

/* src/u16u8_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_decoder
// Surrogate tracking and UTF-8 encoding of one code unit into a byte group.
// ----------------------------------------------------------------------------
module u16u8_decoder (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   unit_accept,
    input  logic [15:0]            code_unit,
    input  logic                   last_unit,
    output logic                   has_result,
    output u16u8_pkg::group_t      grp
);
    import u16u8_pkg::*;

    logic [HeldW-1:0] held_reg;
    logic [HeldW-1:0] held_next;
    logic             pend_reg;
    logic             pend_next;
    logic             disc_reg;
    logic             disc_next;

    logic             is_high;
    logic             is_low;
    logic             err_hit;
    status_t          err_status;
    logic [CpW-1:0]   cp;
    group_t           bmp_grp;
    group_t           supp_grp;

    always_comb
    begin
        is_high = (code_unit[15:10] == HighTag);
        is_low  = (code_unit[15:10] == LowTag);
        cp      = CpW'({held_reg, code_unit[9:0]}) + SuppBase;

        bmp_grp         = '0;
        bmp_grp.str_end = last_unit;
        bmp_grp.status  = ST_OK;
        if (code_unit[15:7] == '0)
        begin
            bmp_grp.cnt      = 2'd0;
            bmp_grp.bytes[0] = {1'b0, code_unit[6:0]};
        end
        else if (code_unit[15:11] == '0)
        begin
            bmp_grp.cnt      = 2'd1;
            bmp_grp.bytes[0] = {3'b110, code_unit[10:6]};
            bmp_grp.bytes[1] = {2'b10, code_unit[5:0]};
        end
        else
        begin
            bmp_grp.cnt      = 2'd2;
            bmp_grp.bytes[0] = {4'b1110, code_unit[15:12]};
            bmp_grp.bytes[1] = {2'b10, code_unit[11:6]};
            bmp_grp.bytes[2] = {2'b10, code_unit[5:0]};
        end

        supp_grp          = '0;
        supp_grp.cnt      = 2'd3;
        supp_grp.str_end  = last_unit;
        supp_grp.status   = ST_OK;
        supp_grp.bytes[0] = {5'b11110, cp[20:18]};
        supp_grp.bytes[1] = {2'b10, cp[17:12]};
        supp_grp.bytes[2] = {2'b10, cp[11:6]};
        supp_grp.bytes[3] = {2'b10, cp[5:0]};

        held_next  = held_reg;
        pend_next  = pend_reg;
        disc_next  = disc_reg;
        has_result = 1'b0;
        grp        = bmp_grp;
        err_hit    = 1'b0;
        err_status = ST_UNPAIRED;

        if (disc_reg)
        begin
            if (last_unit)
                disc_next = 1'b0;
        end
        else if (pend_reg)
        begin
            if (!is_low)
                err_hit = 1'b1;
            else
            begin
                has_result = 1'b1;
                grp        = supp_grp;
                pend_next  = 1'b0;
                held_next  = '0;
            end
        end
        else if (code_unit == '0)
        begin
            err_hit    = 1'b1;
            err_status = ST_NUL;
        end
        else if (is_high)
        begin
            if (last_unit)
                err_hit = 1'b1;
            else
            begin
                held_next = code_unit[HeldW-1:0];
                pend_next = 1'b1;
            end
        end
        else if (is_low)
            err_hit = 1'b1;
        else
            has_result = 1'b1;

        if (err_hit)
        begin
            has_result  = 1'b1;
            grp         = '0;
            grp.str_end = 1'b1;
            grp.status  = err_status;
            pend_next   = 1'b0;
            held_next   = '0;
            disc_next   = !last_unit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            pend_reg <= 1'b0;
            disc_reg <= 1'b0;
        end
        else if (unit_accept)
        begin
            held_reg <= held_next;
            pend_reg <= pend_next;
            disc_reg <= disc_next;
        end
    end

    // a string is either waiting for a low half or being dropped, never both
    assert property (@(posedge clk) disable iff (!rst_n) !(pend_reg && disc_reg))
        else $error("pending surrogate while discarding");

endmodule

/* src/u16u8_serializer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_serializer
// Holds one byte group and sends its bytes one beat at a time.
// ----------------------------------------------------------------------------
module u16u8_serializer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  u16u8_pkg::group_t      in_grp,
    output logic                   grp_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic                   out_run,
    output logic                   out_end,
    output u16u8_pkg::status_t     out_status
);
    import u16u8_pkg::*;

    logic               grp_valid_reg;
    group_t             grp_reg;
    logic [CntW-1:0]    idx_reg;

    logic               out_valid_reg;
    logic [ByteW-1:0]   out_byte_reg;
    logic               out_run_reg;
    logic               out_end_reg;
    status_t            out_status_reg;

    logic               load;
    logic               at_end;
    logic               grp_take;

    always_comb
    begin
        load      = !out_valid_reg || out_ready;
        at_end    = (idx_reg == grp_reg.cnt);
        grp_take  = load && grp_valid_reg && at_end;
        grp_ready = !grp_valid_reg || grp_take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid)
                grp_valid_reg <= 1'b1;
            else if (grp_take)
                grp_valid_reg <= 1'b0;

            if (load)
                out_valid_reg <= grp_valid_reg;

            if (load && grp_valid_reg)
            begin
                if (at_end)
                    idx_reg <= '0;
                else
                    idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            grp_reg <= in_grp;
        if (load && grp_valid_reg)
        begin
            out_byte_reg   <= grp_reg.bytes[idx_reg];
            out_run_reg    <= at_end;
            out_end_reg    <= at_end && grp_reg.str_end;
            out_status_reg <= grp_reg.status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_run    = out_run_reg;
    assign out_end    = out_end_reg;
    assign out_status = out_status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg |-> idx_reg <= grp_reg.cnt)
        else $error("byte index past group size");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> grp_ready)
        else $error("group register overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK)
        |-> (out_byte_reg == '0 && out_run_reg && out_end_reg))
        else $error("malformed error beat");

endmodule

/* verif/utf16_to_utf8_transcoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_tb
// Self-checking bench for the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
// Code units are streamed in as strings and a behavioral decoder in the bench
// predicts every output beat: the UTF-8 bytes of each code point, the error
// beat of a NUL or an unpaired surrogate, and the units dropped after an error.
// A directed pass covers the encoding boundaries and every error path; random
// strings, mostly well formed with some noise, then run under several mixes
// of input gaps and output stalls, one long output hold-off and a phase that
// lets the block drain after every string.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_tb;

    import u16u8_pkg::*;

    localparam int ClkHalf = 2;
    localparam int StallLimit = 2000;
    localparam int DrainCycles = 8;
    localparam int HoldCycles = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       str_end;
        status_t    status;
    } utf8_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;

    utf8_beat_t  utf8_expect_q[$];
    logic [15:0] unit_seq_q[$];

    logic [9:0]  held_bits = '0;
    logic        high_held = 1'b0;
    logic        dropping = 1'b0;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int units_sent = 0;
    int beats_checked = 0;
    int error_beats = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    utf16_to_utf8_transcoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #ClkHalf clk = ~clk;
    end

    task automatic push_code_point(input logic [CpW-1:0] cp, input logic last);
        logic [7:0] b [MaxBytes];
        int n;
        if (cp < 21'h80)
        begin
            b[0] = cp[7:0];
            n = 1;
        end
        else if (cp < 21'h800)
        begin
            b[0] = 8'hc0 | cp[10:6];
            b[1] = 8'h80 | cp[5:0];
            n = 2;
        end
        else if (cp < 21'h10000)
        begin
            b[0] = 8'he0 | cp[15:12];
            b[1] = 8'h80 | cp[11:6];
            b[2] = 8'h80 | cp[5:0];
            n = 3;
        end
        else
        begin
            b[0] = 8'hf0 | cp[20:18];
            b[1] = 8'h80 | cp[17:12];
            b[2] = 8'h80 | cp[11:6];
            b[3] = 8'h80 | cp[5:0];
            n = 4;
        end
        for (int k = 0; k < n; k++)
            utf8_expect_q.push_back('{b[k], k == n - 1, (k == n - 1) && last, ST_OK});
    endtask

    task automatic push_error(input status_t st, input logic last);
        high_held = 1'b0;
        held_bits = '0;
        dropping = !last;
        utf8_expect_q.push_back('{8'h00, 1'b1, 1'b1, st});
    endtask

    task automatic predict_utf8(input logic [15:0] unit, input logic last);
        logic is_high;
        logic is_low;
        logic [CpW-1:0] cp;
        is_high = unit[15:10] == HighTag;
        is_low = unit[15:10] == LowTag;
        if (dropping)
        begin
            if (last)
                dropping = 1'b0;
        end
        else if (high_held)
        begin
            if (!is_low)
                push_error(ST_UNPAIRED, last);
            else
            begin
                cp = SuppBase + {1'b0, held_bits, 10'b0} + {11'b0, unit[9:0]};
                high_held = 1'b0;
                held_bits = '0;
                push_code_point(cp, last);
            end
        end
        else if (unit == 16'h0000)
            push_error(ST_NUL, last);
        else if (is_high)
        begin
            if (last)
                push_error(ST_UNPAIRED, last);
            else
            begin
                held_bits = unit[9:0];
                high_held = 1'b1;
            end
        end
        else if (is_low)
            push_error(ST_UNPAIRED, last);
        else
            push_code_point({5'b0, unit}, last);
    endtask

    task automatic send_unit(input logic [15:0] unit, input logic last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= unit;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_utf8(unit, last);
        units_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (utf8_expect_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // build one string of code points, mostly well formed, some noise units
    task automatic make_unit_seq(input int points, input int noise_pct);
        unit_seq_q.delete();
        repeat (points)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                case ($urandom_range(0, 3))
                    0: unit_seq_q.push_back(16'h0000);
                    1: unit_seq_q.push_back(16'(32'hdc00 + $urandom_range(0, 16'h3ff)));
                    2: unit_seq_q.push_back(16'(32'hd800 + $urandom_range(0, 16'h3ff)));
                    default: unit_seq_q.push_back(16'($urandom_range(0, 16'hffff)));
                endcase
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: unit_seq_q.push_back(16'($urandom_range(1, 16'h7f)));
                    1: unit_seq_q.push_back(16'($urandom_range(16'h80, 16'h7ff)));
                    2:
                    begin
                        if ($urandom_range(0, 1))
                            unit_seq_q.push_back(16'($urandom_range(16'h800, 16'hd7ff)));
                        else
                            unit_seq_q.push_back(16'($urandom_range(16'he000, 16'hffff)));
                    end
                    default:
                    begin
                        unit_seq_q.push_back(16'(32'hd800 + $urandom_range(0, 16'h3ff)));
                        unit_seq_q.push_back(16'(32'hdc00 + $urandom_range(0, 16'h3ff)));
                    end
                endcase
            end
        end
    endtask

    task automatic send_unit_seq();
        for (int i = 0; i < unit_seq_q.size(); i++)
            send_unit(unit_seq_q[i], i == unit_seq_q.size() - 1);
    endtask

    task automatic run_random_strings(input int unit_count);
        int start;
        start = units_sent;
        while (units_sent - start < unit_count)
        begin
            make_unit_seq($urandom_range(1, 8), 10);
            send_unit_seq();
        end
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        send_unit(16'h0041, 1'b0);
        send_unit(16'h007f, 1'b0);
        send_unit(16'h0001, 1'b1);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07ff, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hd7ff, 1'b0);
        send_unit(16'he000, 1'b0);
        send_unit(16'hffff, 1'b1);
        // surrogate pairs at both ends of the range
        send_unit(16'hd800, 1'b0);
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hdbff, 1'b0);
        send_unit(16'hdfff, 1'b1);
        // nul mid string, rest dropped up to the last unit
        send_unit(16'h0000, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hd800, 1'b1);
        // lone low surrogate
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hffff, 1'b1);
        // held high followed by nul on the last unit
        send_unit(16'hd801, 1'b0);
        send_unit(16'h0000, 1'b1);
        // held high followed by another high
        send_unit(16'hdbff, 1'b0);
        send_unit(16'hd800, 1'b0);
        send_unit(16'h0042, 1'b1);
        // high surrogate as the last unit, then nul as the last unit
        send_unit(16'hdabc, 1'b1);
        send_unit(16'h0000, 1'b1);
        send_unit(16'h0043, 1'b1);
        wait_drained();
    endtask

    task automatic test_no_idle();
        idle_pct = 0;
        stall_pct = 0;
        run_random_strings(60);
        wait_drained();
    endtask

    task automatic test_sender_idle();
        idle_pct = 85;
        stall_pct = 0;
        run_random_strings(45);
        wait_drained();
    endtask

    task automatic test_receiver_stall();
        idle_pct = 0;
        stall_pct = 85;
        run_random_strings(45);
        wait_drained();
    endtask

    task automatic test_both_idle();
        idle_pct = 13;
        stall_pct = 13;
        run_random_strings(45);
        wait_drained();
    endtask

    task automatic test_output_hold_off();
        idle_pct = 0;
        stall_pct = 0;
        hold_left = HoldCycles;
        run_random_strings(30);
        wait_drained();
    endtask

    task automatic test_drain_per_string();
        idle_pct = 0;
        stall_pct = 30;
        repeat (8)
        begin
            make_unit_seq($urandom_range(1, 4), 15);
            send_unit_seq();
            wait_drained();
        end
    endtask

    // output side ready, random stalls and the long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                m_tready <= $urandom_range(0, 99) >= stall_pct;
        end
    end

    // compare each output beat with the oldest predicted one
    initial
    begin
        utf8_beat_t want;
        utf8_beat_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = '{m_tdata, m_tlast, m_tuser[0], status_t'(m_tuser[2:1])};
                beats_checked++;
                if (got.status != ST_OK)
                    error_beats++;
                if (utf8_expect_q.size() == 0)
                begin
                    $display("%0t unexpected beat: data %0h last %0b end %0b status %0d",
                             $time, got.data, got.run_end, got.str_end, got.status);
                    mismatches++;
                end
                else
                begin
                    want = utf8_expect_q.pop_front();
                    if (got.data != want.data)
                    begin
                        $display("%0t data: expected %0h actual %0h",
                                 $time, want.data, got.data);
                        mismatches++;
                    end
                    if (got.run_end != want.run_end)
                    begin
                        $display("%0t last_of_run: expected %0b actual %0b",
                                 $time, want.run_end, got.run_end);
                        mismatches++;
                    end
                    if (got.str_end != want.str_end)
                    begin
                        $display("%0t string_end: expected %0b actual %0b",
                                 $time, want.str_end, got.str_end);
                        mismatches++;
                    end
                    if (got.status != want.status)
                    begin
                        $display("%0t status: expected %0d actual %0d",
                                 $time, want.status, got.status);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= StallLimit)
            begin
                $display("%0t watchdog: no beat for %0d cycles, %0d beats outstanding",
                         $time, quiet_cycles, utf8_expect_q.size());
                $display("utf16_to_utf8_transcoder test failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_output_hold_off();
        test_drain_per_string();
        $display("covered %0d code units and %0d output beats, %0d of them error beats",
                 units_sent, beats_checked, error_beats);
        $display("under input gaps, output stalls, a long hold-off and per-string drains");
        if (mismatches == 0 && utf8_expect_q.size() == 0)
            $display("utf16_to_utf8_transcoder test passed");
        else
            $display("utf16_to_utf8_transcoder test failed");
        $finish;
    end

endmodule

/* files.f */
src/u16u8_pkg.sv
src/u16u8_decoder.sv
src/u16u8_serializer.sv
src/utf16_to_utf8_transcoder.sv
verif/utf16_to_utf8_transcoder_tb.sv
